FILE: design/esc_pkg.sv
// shared types, register codes and reset values for the drive mode tracker
package esc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NEUTRAL_ENTER   = 3'd0,
    CFG_NEUTRAL_LEAVE   = 3'd1,
    CFG_CONTROLLER_MODE = 3'd2,
    CFG_DISARM_TICKS    = 3'd3,
    CFG_FWD_AUTOBRAKE   = 3'd4,
    CFG_REV_AUTOBRAKE   = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_FWD_BRAKE_REV = 2'd0,
    MODE_TIMEOUT       = 2'd1,
    MODE_FWD_BRAKE     = 2'd2,
    MODE_FWD_REV       = 2'd3
  } ctrl_mode_t;

  localparam logic [LEVEL_W-1:0] RST_NEUTRAL_ENTER = 16'd10;
  localparam logic [LEVEL_W-1:0] RST_NEUTRAL_LEAVE = 16'd8;
  localparam logic [COUNT_W-1:0] RST_DISARM_TICKS  = 16'd200;
  localparam logic [COUNT_W-1:0] COUNT_ONE         = 16'd1;

  typedef struct packed {
    logic [LEVEL_W-1:0] neutral_enter_level;
    logic [LEVEL_W-1:0] neutral_leave_level;
    ctrl_mode_t         controller_mode;
    logic [COUNT_W-1:0] disarm_ticks;
    logic               forward_autobrake_on;
    logic               reverse_autobrake_on;
  } cfg_t;

  typedef struct packed {
    logic               tick;
    logic               sample_valid;
    logic [LEVEL_W-1:0] throttle_magnitude;
    logic               throttle_negative;
    logic [COUNT_W-1:0] forward_brake_time;
    logic [COUNT_W-1:0] reverse_brake_time;
    logic [COUNT_W-1:0] reverse_hold_time;
  } item_t;

  typedef struct packed {
    logic               forward_flag;
    logic               reverse_flag;
    logic               brake_flag;
    logic               brake_armed_flag;
    logic               use_enter_level;
    logic               disarm_active;
    logic               autobrake_active;
    logic               autoreverse_active;
    logic [COUNT_W-1:0] disarm_count;
    logic [COUNT_W-1:0] autobrake_count;
    logic [COUNT_W-1:0] autoreverse_count;
  } track_state_t;

endpackage

FILE: design/esc_cfg_regs.sv
// configuration register file for the drive mode tracker
module esc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output esc_pkg::cfg_t                  cfg
);
  import esc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.neutral_enter_level  <= RST_NEUTRAL_ENTER;
      cfg.neutral_leave_level  <= RST_NEUTRAL_LEAVE;
      cfg.controller_mode      <= MODE_FWD_BRAKE_REV;
      cfg.disarm_ticks         <= RST_DISARM_TICKS;
      cfg.forward_autobrake_on <= 1'b0;
      cfg.reverse_autobrake_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_NEUTRAL_ENTER:   cfg.neutral_enter_level  <= cfg_data[LEVEL_W-1:0];
        CFG_NEUTRAL_LEAVE:   cfg.neutral_leave_level  <= cfg_data[LEVEL_W-1:0];
        CFG_CONTROLLER_MODE: cfg.controller_mode      <= ctrl_mode_t'(cfg_data[1:0]);
        CFG_DISARM_TICKS:    cfg.disarm_ticks         <= cfg_data[COUNT_W-1:0];
        CFG_FWD_AUTOBRAKE:   cfg.forward_autobrake_on <= cfg_data[0];
        CFG_REV_AUTOBRAKE:   cfg.reverse_autobrake_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/esc_step.sv
// next-state logic: tick timers, then classify the throttle sample
module esc_step (
  input  esc_pkg::cfg_t        cfg,
  input  esc_pkg::item_t       item,
  input  esc_pkg::track_state_t cur,
  output esc_pkg::track_state_t nxt
);
  import esc_pkg::*;

  always_comb begin
    logic [LEVEL_W-1:0] level;
    nxt = cur;

    // timers count down first; reaching zero clears their flags
    if (item.tick) begin
      if (nxt.disarm_active) begin
        nxt.disarm_count = nxt.disarm_count - COUNT_ONE;
        if (nxt.disarm_count == '0) begin
          nxt.disarm_active    = 1'b0;
          nxt.brake_armed_flag = 1'b0;
        end
      end
      if (nxt.autobrake_active) begin
        nxt.autobrake_count = nxt.autobrake_count - COUNT_ONE;
        if (nxt.autobrake_count == '0) begin
          nxt.autobrake_active = 1'b0;
          nxt.brake_flag       = 1'b0;
        end
      end
      if (nxt.autoreverse_active) begin
        nxt.autoreverse_count = nxt.autoreverse_count - COUNT_ONE;
        if (nxt.autoreverse_count == '0) begin
          nxt.autoreverse_active = 1'b0;
          nxt.reverse_flag       = 1'b0;
        end
      end
    end

    level = nxt.use_enter_level ? cfg.neutral_enter_level : cfg.neutral_leave_level;

    if (item.sample_valid) begin
      if (item.throttle_magnitude < level) begin
        // neutral
        nxt.use_enter_level = 1'b1;
        if (nxt.forward_flag) begin
          nxt.forward_flag = 1'b0;
          if (cfg.controller_mode == MODE_TIMEOUT) begin
            nxt.disarm_active = 1'b1;
            nxt.disarm_count  = cfg.disarm_ticks;
          end
          if (cfg.forward_autobrake_on) begin
            nxt.brake_flag       = 1'b1;
            nxt.autobrake_active = 1'b1;
            nxt.autobrake_count  = item.forward_brake_time;
          end
        end else if (nxt.reverse_flag) begin
          if (!nxt.autoreverse_active) begin
            nxt.autoreverse_active = 1'b1;
            nxt.autoreverse_count  = item.reverse_hold_time;
            if (cfg.reverse_autobrake_on) begin
              nxt.brake_flag       = 1'b1;
              nxt.autobrake_active = 1'b1;
              nxt.autobrake_count  = item.reverse_brake_time;
            end
          end
        end else if (nxt.brake_flag && !nxt.autobrake_active) begin
          nxt.brake_armed_flag = 1'b0;
          nxt.brake_flag       = 1'b0;
        end
      end else begin
        // driving
        nxt.use_enter_level  = 1'b0;
        nxt.autobrake_active = 1'b0;
        nxt.disarm_active    = 1'b0;
        if (item.throttle_negative) begin
          if (cfg.controller_mode == MODE_FWD_BRAKE || nxt.brake_armed_flag) begin
            nxt.brake_flag   = 1'b1;
            nxt.forward_flag = 1'b0;
            nxt.reverse_flag = 1'b0;
          end else begin
            nxt.reverse_flag       = 1'b1;
            nxt.brake_flag         = 1'b0;
            nxt.forward_flag       = 1'b0;
            nxt.autoreverse_active = 1'b0;
          end
        end else begin
          nxt.forward_flag = 1'b1;
          nxt.reverse_flag = 1'b0;
          nxt.brake_flag   = 1'b0;
          if (cfg.controller_mode != MODE_FWD_REV) nxt.brake_armed_flag = 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/esc_drive_mode_tracker_core.sv
// top level of the drive mode tracker: input stage, state, result register
// Drive mode tracker for a speed controller. Each input transaction carries an
// optional tick and an optional throttle sample together with the random
// auto brake and auto reverse durations; each one yields exactly one output
// transaction with the forward, reverse and brake flags after the update. The
// tick is applied first (all three countdown timers step together), then the
// sample is classed against the hysteresis level in force. A transaction is
// registered on entry; once the result register is free, the state update
// and the result register load happen together. One transaction is accepted
// every cycle while the output does not stall; the state update loop is what
// sets that rate. While a finished result waits, the input stays ready only
// if the input stage is empty. Write registers via cfg_we/cfg_index/cfg_data
// (no read-back) only while idle; the block itself does not enforce it.
module esc_drive_mode_tracker_core (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [esc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tick[0], throttle_magnitude[16:1], throttle_negative[17],
  // forward_brake_time[33:18], reverse_brake_time[49:34],
  // reverse_hold_time[65:50], zero pad[71:66]
  input  logic [esc_pkg::IN_DATA_W-1:0]    s_tdata,
  // sample_valid
  input  logic                             s_tuser,
  // output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // going_forward[0], going_reverse[1], brake_on[2], zero pad[7:3]
  output logic [esc_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import esc_pkg::*;

  cfg_t         cfg;
  item_t        item;
  logic         item_valid;
  track_state_t state;
  track_state_t state_next;
  logic         out_free;
  logic         advance;

  esc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // result register can take a new value when empty or being drained
  assign out_free = !m_tvalid || m_tready;
  assign advance  = item_valid && out_free;
  assign s_tready = !item_valid || out_free;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.tick               <= s_tdata[0];
      item.sample_valid       <= s_tuser;
      item.throttle_magnitude <= s_tdata[16:1];
      item.throttle_negative  <= s_tdata[17];
      item.forward_brake_time <= s_tdata[33:18];
      item.reverse_brake_time <= s_tdata[49:34];
      item.reverse_hold_time  <= s_tdata[65:50];
    end
  end

  esc_step u_step (
    .cfg  (cfg),
    .item (item),
    .cur  (state),
    .nxt  (state_next)
  );

  // tracker state, updated once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{use_enter_level: 1'b1, default: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(OUT_DATA_W-3){1'b0}}, state_next.brake_flag,
                  state_next.reverse_flag, state_next.forward_flag};
    end
  end

endmodule

FILE: design/esc_checker.sv
// port-level checks for the drive mode tracker, bound to the top level
module esc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [esc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import esc_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // forward excludes reverse and brake
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && (m_tdata[1] || m_tdata[2])))
    else $error("forward reported with reverse or brake");

  // input only stalls behind a stalled full result register
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind esc_drive_mode_tracker_core esc_checker u_esc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
